// ===== sv/cfla_pkg.sv =====
package cfla_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned SlotsDef       = 64;
  localparam int unsigned HeaderBytesDef = 24;

  // Command codes.
  localparam logic [1:0] CMD_FREE  = 2'd0;
  localparam logic [1:0] CMD_ALLOC = 2'd1;
  localparam logic [1:0] CMD_PEEK  = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // One free segment as it is stored in the table.
  typedef struct packed {
    logic [31:0] start;
    logic [31:0] size;
  } entry_t;

  // Write port of the segment table.
  typedef struct packed {
    logic   we;
    entry_t wdata;
  } wr_ctl_t;

endpackage

// ===== sv/cfla_if.sv =====
interface cfla_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] seg_start;
  logic [31:0] req_size;

  modport source(output valid, command, seg_start, req_size, input ready);
  modport sink(input valid, command, seg_start, req_size, output ready);
endinterface

interface cfla_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] address;
  logic [31:0] leftover;
  logic [31:0] merged_size;

  modport source(output valid, status, address, leftover, merged_size, input ready);
  modport sink(input valid, status, address, leftover, merged_size, output ready);
endinterface

// ===== sv/cfla_mem.sv =====
module cfla_mem #(
  parameter int unsigned DEPTH = cfla_pkg::SlotsDef
) (
  input  logic                     clk_i,
  input  cfla_pkg::wr_ctl_t        wr_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output cfla_pkg::entry_t         rdata_o
);
  import cfla_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_q;

  // Synchronous write and registered read.
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[waddr_i] <= wr_i.wdata;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/coalescing_free_list_allocator.sv =====
// Channel  Dir  Fields                                     Transfer
// in_i     in   command, seg_start, req_size               valid && ready
// out_o    out  status, address, leftover, merged_size     valid && ready
//
// Each command is handled alone; a new one is taken only when the sequencer is idle.
// Each table entry visited takes a read step and an evaluate or write step on the table memory;
// a command may run a fit or neighbor scan, removals that shift the later entries down and a
// head insert that shifts the entries up, each walking the table one entry at a time.
// Reset empties the table at once through the entry count; no clearing pass is run.
// A finished result waits in the output register; the next command is taken meanwhile.
module coalescing_free_list_allocator #(
  parameter int unsigned SLOTS        = cfla_pkg::SlotsDef,
  parameter int unsigned HEADER_BYTES = cfla_pkg::HeaderBytesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cfla_in_if.sink    in_i,
  cfla_out_if.source out_o
);
  import cfla_pkg::*;

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_FIT_RD = 12'b000000000010,
    S_FIT_EV = 12'b000000000100,
    S_NB_RD  = 12'b000000001000,
    S_NB_EV  = 12'b000000010000,
    S_PLAN   = 12'b000000100000,
    S_DEL_RD = 12'b000001000000,
    S_DEL_WR = 12'b000010000000,
    S_INS_RD = 12'b000100000000,
    S_INS_WR = 12'b001000000000,
    S_HEAD   = 12'b010000000000,
    S_RESP   = 12'b100000000000
  } state_e;

  state_e      state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d, idx_q, idx_d;
  logic [1:0]  cmd_q, cmd_d;
  logic [31:0] seg_q, seg_d, size_q, size_d;
  logic        quiet_q, quiet_d, reins_q, reins_d, ins_pend_q, ins_pend_d;
  logic        del1_v_q, del1_v_d;
  logic [IW-1:0] del1_idx_q, del1_idx_d;
  logic        pred_v_q, pred_v_d, succ_v_q, succ_v_d;
  logic [IW-1:0] pred_idx_q, pred_idx_d, succ_idx_q, succ_idx_d;
  entry_t      pred_q, pred_d, succ_q, succ_d;
  entry_t      new_q, new_d;
  logic [1:0]  res_st_q, res_st_d;
  logic [31:0] res_addr_q, res_addr_d, res_left_q, res_left_d, res_msz_q, res_msz_d;
  logic        out_v_q, out_v_d;
  logic [1:0]  o_st_q, o_st_d;
  logic [31:0] o_addr_q, o_addr_d, o_left_q, o_left_d, o_msz_q, o_msz_d;

  wr_ctl_t     wr;
  logic [IW-1:0] waddr, raddr;
  entry_t      rdata;

  logic [31:0] rem;
  logic [32:0] ent_end, seg_end;
  logic        succ_use;
  logic [33:0] sum;

  cfla_mem #(.DEPTH(SLOTS)) u_mem (
    .clk_i  (clk_i),
    .wr_i   (wr),
    .waddr_i(waddr),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = out_v_q;
  assign out_o.status      = o_st_q;
  assign out_o.address     = o_addr_q;
  assign out_o.leftover    = o_left_q;
  assign out_o.merged_size = o_msz_q;

  assign rem      = rdata.size - size_q;
  assign ent_end  = {1'b0, rdata.start} + {1'b0, rdata.size};
  assign seg_end  = {1'b0, seg_q} + {1'b0, size_q};
  assign succ_use = succ_v_q && !(pred_v_q && (pred_idx_q == succ_idx_q));
  assign sum      = {2'b00, size_q} + (pred_v_q ? {2'b00, pred_q.size} : 34'd0)
                  + (succ_use ? {2'b00, succ_q.size} : 34'd0);

  // Command sequencer: scans, removals and head insertion over the table memory.
  always_comb begin
    state_d = state_q;  cnt_d = cnt_q;  idx_d = idx_q;  cmd_d = cmd_q;
    seg_d = seg_q;  size_d = size_q;  quiet_d = quiet_q;  reins_d = reins_q;
    ins_pend_d = ins_pend_q;  del1_v_d = del1_v_q;  del1_idx_d = del1_idx_q;
    pred_v_d = pred_v_q;  succ_v_d = succ_v_q;  pred_idx_d = pred_idx_q;
    succ_idx_d = succ_idx_q;  pred_d = pred_q;  succ_d = succ_q;  new_d = new_q;
    res_st_d = res_st_q;  res_addr_d = res_addr_q;  res_left_d = res_left_q;
    res_msz_d = res_msz_q;
    out_v_d = out_v_q;  o_st_d = o_st_q;  o_addr_d = o_addr_q;
    o_left_d = o_left_q;  o_msz_d = o_msz_q;
    wr.we = 1'b0;  wr.wdata = rdata;
    waddr = idx_q[IW-1:0];  raddr = idx_q[IW-1:0];

    if (out_v_q && out_o.ready) begin
      out_v_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          cmd_d = in_i.command;  seg_d = in_i.seg_start;  size_d = in_i.req_size;
          idx_d = '0;  quiet_d = 1'b0;  pred_v_d = 1'b0;  succ_v_d = 1'b0;
          state_d = (in_i.command == CMD_FREE) ? S_NB_RD : S_FIT_RD;
        end
      end
      S_FIT_RD: begin
        if (idx_q == cnt_q) begin
          res_st_d = ST_NOFIT;  res_addr_d = '0;  res_left_d = '0;  res_msz_d = '0;
          state_d = S_RESP;
        end else begin
          state_d = S_FIT_EV;
        end
      end
      S_FIT_EV: begin
        if (rdata.size >= size_q) begin
          res_st_d = ST_OK;  res_addr_d = rdata.start;  res_msz_d = '0;
          res_left_d = (rem != '0 && rem < 32'(HEADER_BYTES)) ? rem : '0;
          if (cmd_q == CMD_ALLOC) begin
            // Remove the chosen segment; a large remainder is freed again afterward.
            idx_d = idx_q + 1'b1;  del1_v_d = 1'b0;  ins_pend_d = 1'b0;
            reins_d = (rem >= 32'(HEADER_BYTES));  quiet_d = 1'b1;
            seg_d = rdata.start + size_q;  size_d = rem;
            state_d = S_DEL_RD;
          end else begin
            state_d = S_RESP;
          end
        end else begin
          idx_d = idx_q + 1'b1;
          state_d = S_FIT_RD;
        end
      end
      S_NB_RD: begin
        state_d = (idx_q == cnt_q) ? S_PLAN : S_NB_EV;
      end
      S_NB_EV: begin
        // First entry ending at the new start and first entry starting at its end.
        if (!pred_v_q && ent_end == {1'b0, seg_q}) begin
          pred_v_d = 1'b1;  pred_idx_d = idx_q[IW-1:0];  pred_d = rdata;
        end
        if (!succ_v_q && {1'b0, rdata.start} == seg_end) begin
          succ_v_d = 1'b1;  succ_idx_d = idx_q[IW-1:0];  succ_d = rdata;
        end
        idx_d = idx_q + 1'b1;
        state_d = S_NB_RD;
      end
      S_PLAN: begin
        if (!pred_v_q && !succ_use && cnt_q == CW'(SLOTS)) begin
          if (!quiet_q) begin
            res_st_d = ST_FULL;  res_addr_d = seg_q;  res_left_d = '0;  res_msz_d = '0;
          end
          state_d = S_RESP;
        end else begin
          new_d.start = pred_v_q ? pred_q.start : seg_q;
          new_d.size  = (sum[33:32] != 2'b00) ? 32'hFFFF_FFFF : sum[31:0];
          if (!quiet_q) begin
            res_st_d = ST_OK;  res_addr_d = new_d.start;  res_left_d = '0;
            res_msz_d = new_d.size;
          end
          ins_pend_d = 1'b1;
          if (pred_v_q && succ_use) begin
            // Remove the higher index first so the lower one stays in place.
            del1_v_d = 1'b1;
            if (pred_idx_q > succ_idx_q) begin
              idx_d = CW'(pred_idx_q) + 1'b1;  del1_idx_d = succ_idx_q;
            end else begin
              idx_d = CW'(succ_idx_q) + 1'b1;  del1_idx_d = pred_idx_q;
            end
            state_d = S_DEL_RD;
          end else if (pred_v_q || succ_use) begin
            del1_v_d = 1'b0;
            idx_d = CW'(pred_v_q ? pred_idx_q : succ_idx_q) + 1'b1;
            state_d = S_DEL_RD;
          end else begin
            ins_pend_d = 1'b0;  idx_d = cnt_q;
            state_d = S_INS_RD;
          end
        end
      end
      S_DEL_RD: begin
        if (idx_q == cnt_q) begin
          // Removal done; pick the next step.
          cnt_d = cnt_q - 1'b1;
          if (del1_v_q) begin
            del1_v_d = 1'b0;  idx_d = CW'(del1_idx_q) + 1'b1;
          end else if (ins_pend_q) begin
            ins_pend_d = 1'b0;  idx_d = cnt_q - 1'b1;  state_d = S_INS_RD;
          end else if (reins_q) begin
            reins_d = 1'b0;  idx_d = '0;  pred_v_d = 1'b0;  succ_v_d = 1'b0;
            state_d = S_NB_RD;
          end else begin
            state_d = S_RESP;
          end
        end else begin
          state_d = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        wr.we = 1'b1;  waddr = IW'(idx_q - 1'b1);
        idx_d = idx_q + 1'b1;
        state_d = S_DEL_RD;
      end
      S_INS_RD: begin
        raddr = IW'(idx_q - 1'b1);
        state_d = (idx_q == '0) ? S_HEAD : S_INS_WR;
      end
      S_INS_WR: begin
        wr.we = 1'b1;
        idx_d = idx_q - 1'b1;
        state_d = S_INS_RD;
      end
      S_HEAD: begin
        wr.we = 1'b1;  wr.wdata = new_q;  waddr = '0;
        cnt_d = cnt_q + 1'b1;
        state_d = S_RESP;
      end
      S_RESP: begin
        if (!out_v_q || out_o.ready) begin
          out_v_d = 1'b1;  o_st_d = res_st_q;  o_addr_d = res_addr_q;
          o_left_d = res_left_q;  o_msz_d = res_msz_q;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      out_v_q    <= 1'b0;
      ins_pend_q <= 1'b0;
      reins_q    <= 1'b0;
      del1_v_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      out_v_q    <= out_v_d;
      ins_pend_q <= ins_pend_d;
      reins_q    <= reins_d;
      del1_v_q   <= del1_v_d;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;  cmd_q <= cmd_d;  seg_q <= seg_d;  size_q <= size_d;
    quiet_q <= quiet_d;  del1_idx_q <= del1_idx_d;
    pred_v_q <= pred_v_d;  succ_v_q <= succ_v_d;
    pred_idx_q <= pred_idx_d;  succ_idx_q <= succ_idx_d;
    pred_q <= pred_d;  succ_q <= succ_d;  new_q <= new_d;
    res_st_q <= res_st_d;  res_addr_q <= res_addr_d;
    res_left_q <= res_left_d;  res_msz_q <= res_msz_d;
    o_st_q <= o_st_d;  o_addr_q <= o_addr_d;  o_left_q <= o_left_d;  o_msz_q <= o_msz_d;
  end

  // The entry count never exceeds the table size.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(SLOTS)) else $error("entry count above table size");

  // An accepted command keeps the sequencer busy in the next cycle.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready) else $error("sequencer idle after transfer");

  // The table is written only by removal, shift and head steps.
  a_wr_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.we |-> (state_q == S_DEL_WR || state_q == S_INS_WR || state_q == S_HEAD))
    else $error("table write outside update steps");

  // A head insert never happens on a full table.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_HEAD) |-> (cnt_q < CW'(SLOTS))) else $error("insert into full table");

endmodule
